// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_PROP(lbl, clk, rst, !(cond), msg)

`endif

// File: rtl/wmf_pkg.sv
// shared widths, defaults and cell link type for the window median filter
package wmf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MEDIAN_W   = SAMPLE_W + 1;
   localparam int WINDOW_DEF = 10;

   // what one cell hands to its right neighbor
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                gt;
   } link_type;

endpackage

// File: rtl/wmf_cell.sv
// one insertion cell of the sorted window chain
module wmf_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 4
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [CNT_W-1:0]             fill,
   input  logic [wmf_pkg::SAMPLE_W-1:0] sample,
   input  wmf_pkg::link_type            left,
   output wmf_pkg::link_type            right
);
   import wmf_pkg::*;

   localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

   logic [SAMPLE_W-1:0] value_ff;
   logic [SAMPLE_W-1:0] value_in;
   logic                occupied;
   logic                gt;
   logic                write_en;

   // entry holds a sample of this window and is larger than the new one
   assign occupied = POS < fill;
   assign gt       = occupied && (value_ff > sample);

   // shift right when larger, take the new word at the first free slot
   assign write_en = load && (gt || (fill == POS));
   assign value_in = left.gt ? left.value : sample;

   always_ff @(posedge clock) begin
      if (write_en) begin
         value_ff <= value_in;
      end
   end

   // hand value and compare result to the next cell
   assign right.value = value_ff;
   assign right.gt    = gt;

endmodule

// File: rtl/window_median_filter.sv
// window median filter: one sample word per cycle, busy never asserts.
// a result strobe follows the last sample of each window via done_ff, then rsp_valid_ff.
// throughput is one sample per cycle, set by the insertion cell chain,
// where each cell decides shift/load/hold from its own compare, the fill and its left neighbor.
// synchronous reset clears the fill count and the result strobe; the
// sample cells hold no reset value and are filled anew in every window.
module window_median_filter #(
   parameter int WINDOW = wmf_pkg::WINDOW_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [wmf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                         rsp_valid,
   output logic [wmf_pkg::MEDIAN_W-1:0] rsp_median_doubled
);
   import wmf_pkg::*;

   localparam int CNT_W = $clog2(WINDOW);
   localparam int HALF  = WINDOW / 2;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW - 1);

   logic                accept;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                done_ff;
   logic                done_in;
   logic                rsp_valid_ff;
   logic [MEDIAN_W-1:0] median_ff;
   logic [MEDIAN_W-1:0] median_in;
   link_type            links [WINDOW+1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // fill count and window-complete flag
   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      if (accept) begin
         if (count_ff == LAST) begin
            count_in = '0;
            done_in  = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= done_ff;
      end
   end

   // insertion chain, cell 0 sees no larger left neighbor
   assign links[0] = '0;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      wmf_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock  (clock),
         .load   (accept),
         .fill   (count_ff),
         .sample (req_sample),
         .left   (links[i]),
         .right  (links[i+1])
      );
   end

   // doubled median from the middle cells of the sorted chain
   if ((WINDOW % 2) == 0) begin : g_even
      assign median_in = {1'b0, links[HALF].value} + {1'b0, links[HALF+1].value};
   end else begin : g_odd
      assign median_in = {links[HALF+1].value, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (done_ff) begin
         median_ff <= median_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;

endmodule

// File: rtl/wmf_checker.sv
// port-level checks for the window median filter, bound to the top level
`include "assert_macros.svh"

module wmf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [wmf_pkg::SAMPLE_W-1:0] req_sample,
   input logic                         rsp_valid,
   input logic [wmf_pkg::MEDIAN_W-1:0] rsp_median_doubled
);
   import wmf_pkg::*;

   logic [MEDIAN_W-1:0] max_doubled;
   logic                sample_seen;

   assign max_doubled = {{(MEDIAN_W-SAMPLE_W){1'b0}}, {SAMPLE_W{1'b1}}} << 1;
   assign sample_seen = start && !busy && (req_sample == req_sample);

   // the sample chain can take a word in every cycle
   `ASSERT_NEVER(a_never_busy, clock, reset, busy, "busy asserted")

   // a window holds more than one word, so strobes never touch
   `ASSERT_PROP(a_strobe_gap, clock, reset, rsp_valid |=> !rsp_valid, "strobes back to back")

   // each strobe closes a window whose last word was taken earlier
   `ASSERT_PROP(a_strobe_cause, clock, reset, rsp_valid |-> $past(sample_seen, 2), "strobe without a sample")

   // the doubled median of 16-bit words stays within twice the largest word
   `ASSERT_PROP(a_range, clock, reset, rsp_valid |-> (rsp_median_doubled <= max_doubled), "result out of range")

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_sample         (req_sample),
   .rsp_valid          (rsp_valid),
   .rsp_median_doubled (rsp_median_doubled)
);

// File: tb/tb_window_median_filter.sv
// testbench for the window median filter: queued sample words, predicted doubled medians
`timescale 1ns / 100ps

module tb_window_median_filter;
   import wmf_pkg::*;

   localparam int WINDOW       = WINDOW_DEF;
   localparam int RANDOM_WORDS = 2000;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;
   localparam int MAX_REPORTS  = 10;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [MEDIAN_W-1:0] median_type;

   // one sample word waiting to be sent; settle_first holds it until all medians are in
   typedef struct {
      sample_type sample;
      bit         settle_first;
   } sample_word_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   sample_type req_sample;
   logic       rsp_valid;
   median_type rsp_median_doubled;

   sample_word_type sample_words[$];
   median_type      median_queue[$];

   // predictor state: sorted window contents and fill count
   sample_type window_sorted[WINDOW];
   int         window_fill = 0;

   int offered_count = 0;
   int taken_count   = 0;
   int burst_left    = 1;
   int idle_left     = 0;
   int mismatch_count = 0;
   int stall_cycles  = 0;

   window_median_filter #(.WINDOW(WINDOW)) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_median_doubled (rsp_median_doubled)
   );

   // insert a sample in place and queue the doubled median when the window fills
   task automatic insert_sample(input sample_type s);
      int pos;
      median_type doubled;
      pos = window_fill;
      while (pos > 0 && window_sorted[pos-1] > s) begin
         window_sorted[pos] = window_sorted[pos-1];
         pos--;
      end
      window_sorted[pos] = s;
      window_fill++;
      if (window_fill == WINDOW) begin
         if (WINDOW % 2 == 0)
            doubled = {1'b0, window_sorted[WINDOW/2-1]} + {1'b0, window_sorted[WINDOW/2]};
         else
            doubled = {window_sorted[WINDOW/2], 1'b0};
         median_queue.push_back(doubled);
         window_fill = 0;
      end
   endtask

   task automatic add_word(input sample_type s, input bit settle);
      sample_word_type w;
      w.sample       = s;
      w.settle_first = settle;
      sample_words.push_back(w);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sender: bursts of random length with random gaps, word held until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && offered_count != taken_count)) begin
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (sample_words.size() == 0 ||
                      (sample_words[0].settle_first && median_queue.size() != 0)) begin
            start <= 1'b0;
         end else begin
            start      <= 1'b1;
            req_sample <= sample_words[0].sample;
            offered_count++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
      end
   end

   // monitor: check medians, predict on each taken sample word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (median_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected median word: got %0d", rsp_median_doubled);
            end else begin
               if (rsp_median_doubled !== median_queue[0]) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("median mismatch: expected %0d got %0d",
                              median_queue[0], rsp_median_doubled);
               end
               void'(median_queue.pop_front());
            end
         end
         if (start && !busy) begin
            insert_sample(req_sample);
            void'(sample_words.pop_front());
            taken_count++;
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int mode;
      sample_type s;
      reset      = 1'b1;
      start      = 1'b0;
      req_sample = '0;

      // window of all maximum samples: largest median
      for (int i = 0; i < WINDOW; i++)
         add_word(16'hFFFF, 1'b0);
      // maxima first, then a majority of zeros: median of zero, inserts at the bottom
      for (int i = 0; i < WINDOW; i++)
         add_word((i < WINDOW/2 - 1) ? 16'hFFFF : 16'h0000, 1'b0);
      // alternating extremes with many equal samples: odd doubled median
      for (int i = 0; i < WINDOW; i++)
         add_word((i % 2 == 0) ? 16'hFFFF : 16'h0000, 1'b0);

      // random words; a few wait for all medians to drain first
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         mode = $urandom_range(0, 4);
         case (mode)
            0: s = sample_type'($urandom_range(0, 15));
            1: s = sample_type'(32'hFFFF - $urandom_range(0, 15));
            2: s = sample_type'($urandom_range(0, 3) * 32'h5555);
            default: s = sample_type'($urandom_range(0, 16'hFFFF));
         endcase
         add_word(s, (i == 0) || ($urandom_range(0, 299) == 0));
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until every word is taken and every median has arrived
      while (sample_words.size() != 0 || median_queue.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && median_queue.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/wmf_pkg.sv
rtl/wmf_cell.sv
rtl/window_median_filter.sv
rtl/wmf_checker.sv
tb/tb_window_median_filter.sv
